[rtl/pfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg - shared types and constants for the paging frame allocator
// Request codes, status codes, the wave that travels along the frame cells,
// the divider handshake and the controller states.
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int ID_W    = 16;
	localparam int BYTES_W = 24;
	localparam int PS_W    = 16;
	localparam int CNT_W   = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_STEPS  = BYTES_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES    = CFG_IDX_W'(1);

	localparam logic [PS_W-1:0]  PAGE_SIZE_RESET = PS_W'(4096);
	localparam logic [CNT_W-1:0] FRAMES_RESET    = CNT_W'(64);
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_DUP      = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_CHECK = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} wave_op_t;

	typedef struct packed {
		logic             active;
		wave_op_t         op;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] remain;
		logic [CNT_W-1:0] count;
		logic             hit;
	} wave_t;

	typedef struct packed {
		logic               start;
		logic [BYTES_W-1:0] dividend;
		logic [PS_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [BYTES_W-1:0] pages;
	} div_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ALLOC,
		S_FREE,
		S_REPLY
	} state_t;

	// Frames actually managed: the written count, capped at the table size.
	function automatic logic [CNT_W-1:0] managed_count(input logic [CNT_W-1:0] fiu,
		input logic [CNT_W-1:0] cap);
		managed_count = (fiu > cap) ? cap : fiu;
	endfunction

endpackage
`default_nettype wire

[rtl/pfa_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ifs - channel interfaces of the paging frame allocator
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface pfa_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] proc_id;
	logic [23:0] proc_bytes;
	modport source (output valid, cmd, proc_id, proc_bytes, input ready);
	modport sink   (input valid, cmd, proc_id, proc_bytes, output ready);
endinterface

interface pfa_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] free_count;
	logic [6:0] frames_moved;
	modport source (output valid, status, free_count, frames_moved, input ready);
	modport sink   (input valid, status, free_count, frames_moved, output ready);
endinterface

interface pfa_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/pfa_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_div - page count divider
// Restoring divider, one quotient bit a cycle, then a rounding step that
// turns quotient and remainder into a page count rounded up.
// ----------------------------------------------------------------------------
module pfa_div import pfa_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BYTES_W-1:0]   dvd_q;
	logic [PS_W-1:0]      rem_q;
	logic [PS_W-1:0]      dvs_q;
	logic [BYTES_W-1:0]   pages_q;

	logic [PS_W:0] trial;
	logic [PS_W:0] diff;
	logic          ge;

	assign trial = {rem_q, dvd_q[BYTES_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			// a zero page size divides as one
			dvs_q <= (req.divisor == '0) ? PS_W'(1) : req.divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? diff[PS_W-1:0] : trial[PS_W-1:0];
			dvd_q <= {dvd_q[BYTES_W-2:0], ge};
		end
		if (busy_q && cnt_q == '0) begin
			pages_q <= dvd_q + BYTES_W'(rem_q != '0);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.pages = pages_q;

endmodule
`default_nettype wire

[rtl/pfa_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_cell - one frame of the allocation table
// Holds owner and valid bit, acts on the passing wave and hands it on.
// ----------------------------------------------------------------------------
module pfa_cell import pfa_pkg::*; #(
	parameter int INDEX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire logic [CNT_W-1:0] managed,
	input  wire wave_t            wave_in,
	output wave_t                 wave_out
);

	logic            valid_q;
	logic [ID_W-1:0] owner_q;
	wave_t           wave_q;
	wave_t           wave_nx;
	logic            en;
	logic            match;
	logic            take;
	logic            drop;

	assign en    = 11'(INDEX) < {4'b0, managed};
	assign match = valid_q && (owner_q == wave_in.id);

	always_comb begin
		wave_nx = wave_in;
		take    = 1'b0;
		drop    = 1'b0;
		if (wave_in.active) begin
			unique case (wave_in.op)
				OP_CHECK: begin
					wave_nx.hit = wave_in.hit | match;
				end
				OP_ALLOC: begin
					if (wave_in.remain != '0 && !valid_q && en) begin
						take           = 1'b1;
						wave_nx.remain = wave_in.remain - 1'b1;
						wave_nx.count  = wave_in.count + 1'b1;
					end
				end
				OP_FREE: begin
					if (match) begin
						drop          = 1'b1;
						wave_nx.count = wave_in.count + 1'b1;
					end
				end
				default: begin
					wave_nx.active = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			wave_q  <= '0;
		end else begin
			wave_q <= wave_nx;
			if (clr) begin
				valid_q <= 1'b0;
			end else if (take) begin
				valid_q <= 1'b1;
			end else if (drop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			owner_q <= wave_in.id;
		end
	end

	assign wave_out = wave_q;

endmodule
`default_nettype wire

[rtl/pfa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl - request sequencer of the paging frame allocator
// Launches waves into the cell row, runs the divider, keeps the free count
// and holds the response register.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; #(
	parameter int NUM_FRAMES = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	pfa_req_if.sink               req,
	pfa_rsp_if.source             rsp,
	input  wire logic [PS_W-1:0]  page_size,
	input  wire logic             clr,
	input  wire logic [CNT_W-1:0] clr_count,
	output wave_t                 launch,
	input  wire wave_t            tail,
	output div_req_t              div_req,
	input  wire div_rsp_t         div_rsp
);

	localparam logic [CNT_W-1:0] FRAME_CAP =
		CNT_W'((NUM_FRAMES > CNT_MAX) ? CNT_MAX : NUM_FRAMES);
	localparam logic [CNT_W-1:0] FREE_RESET = managed_count(FRAMES_RESET, FRAME_CAP);

	state_t           state_q, state_nx;
	logic [ID_W-1:0]  id_q;
	logic             hit_q;
	logic             scan_done_q;
	logic [CNT_W-1:0] free_q;
	status_t          res_status_q;
	logic [CNT_W-1:0] res_moved_q;
	wave_t            launch_q, launch_d;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [CNT_W-1:0] out_free_q;
	logic [CNT_W-1:0] out_moved_q;

	logic accept;
	logic chk_go;
	logic too_big;
	logic alloc_go;
	logic out_free_slot;

	assign accept        = req.valid && req.ready;
	assign chk_go        = (state_q == S_CHECK) && scan_done_q && div_rsp.done;
	assign too_big       = div_rsp.pages > BYTES_W'(free_q);
	assign alloc_go      = chk_go && !too_big && !hit_q && (div_rsp.pages != '0);
	assign out_free_slot = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = (req.cmd == CMD_FREE) ? S_FREE : S_CHECK;
				end
			end
			S_CHECK: begin
				if (alloc_go) begin
					state_nx = S_ALLOC;
				end else if (chk_go) begin
					state_nx = S_REPLY;
				end
			end
			S_ALLOC, S_FREE: begin
				if (tail.active) begin
					state_nx = S_REPLY;
				end
			end
			S_REPLY: begin
				if (out_free_slot) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// launch wave and divider start
	always_comb begin
		launch_d         = '0;
		div_req.start    = 1'b0;
		div_req.dividend = req.proc_bytes;
		div_req.divisor  = page_size;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					launch_d.active = 1'b1;
					launch_d.op     = (req.cmd == CMD_FREE) ? OP_FREE : OP_CHECK;
					launch_d.id     = req.proc_id;
					div_req.start   = (req.cmd == CMD_ALLOC);
				end
			end
			S_CHECK: begin
				if (alloc_go) begin
					launch_d.active = 1'b1;
					launch_d.op     = OP_ALLOC;
					launch_d.id     = id_q;
					launch_d.remain = div_rsp.pages[CNT_W-1:0];
				end
			end
			default: begin
				launch_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launch_q    <= '0;
			scan_done_q <= 1'b0;
			free_q      <= FREE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			launch_q <= launch_d;
			if (accept) begin
				scan_done_q <= 1'b0;
			end else if (state_q == S_CHECK && tail.active) begin
				scan_done_q <= 1'b1;
			end
			if (clr) begin
				free_q <= clr_count;
			end else if (state_q == S_ALLOC && tail.active) begin
				free_q <= free_q - tail.count;
			end else if (state_q == S_FREE && tail.active) begin
				free_q <= free_q + tail.count;
			end
			if (state_q == S_REPLY && out_free_slot) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= req.proc_id;
		end
		if (state_q == S_CHECK && tail.active) begin
			hit_q <= tail.hit;
		end
		if (chk_go && !alloc_go) begin
			res_moved_q <= '0;
			if (too_big) begin
				res_status_q <= ST_NOSPACE;
			end else if (hit_q) begin
				res_status_q <= ST_DUP;
			end else begin
				res_status_q <= ST_OK;
			end
		end else if ((state_q == S_ALLOC || state_q == S_FREE) && tail.active) begin
			res_moved_q <= tail.count;
			if (state_q == S_FREE && tail.count == '0) begin
				res_status_q <= ST_UNKNOWN;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (state_q == S_REPLY && out_free_slot) begin
			out_status_q <= res_status_q;
			out_free_q   <= free_q;
			out_moved_q  <= res_moved_q;
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign launch           = launch_q;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.free_count   = out_free_q;
	assign rsp.frames_moved = out_moved_q;

endmodule
`default_nettype wire

[rtl/paging_frame_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// paging_frame_allocator - first-fit paged frame allocation table
// A row of frame cells, each holding an owner id and a valid bit, walked by
// a wave per request, with a divider for the page count and a sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                | transaction
//  --------+-----+----------------------------------------+-------------------
//  req     | in  | cmd, proc_id, proc_bytes               | one request
//  rsp     | out | status, free_count, frames_moved       | one reply
//  cfg     | in  | index (0 page_size, 1 frames_in_use),  | one register write
//          |     | data                                   |
//
//  A deallocate sends one wave along the cell row; an allocate first sends
//  one wave along the cell row to look for a duplicate id while the
//  24-step divider runs, then a claiming wave, unless it is refused or asks
//  for no pages. The wave crosses one cell per cycle; one request is in
//  flight at a time.
//  Reset clears every valid bit at once; there is no clearing pass.
//  A reply waits in the output register while rsp stalls; the next request
//  is taken in the meantime and holds in its reply state until it drains.
//
module paging_frame_allocator import pfa_pkg::*; #(
	parameter int NUM_FRAMES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pfa_req_if.sink   req,
	pfa_rsp_if.source rsp,
	pfa_cfg_if.sink   cfg
);

	localparam logic [CNT_W-1:0] FRAME_CAP =
		CNT_W'((NUM_FRAMES > CNT_MAX) ? CNT_MAX : NUM_FRAMES);

	logic [PS_W-1:0]  page_size_q;
	logic [CNT_W-1:0] frames_in_use_q;
	logic [CNT_W-1:0] managed;
	logic [CNT_W-1:0] clr_count;
	logic             cfg_wr;
	logic             clr;

	wave_t    chain [NUM_FRAMES+1];
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Configuration is taken unchecked; the user sends it only while idle.
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign clr       = cfg_wr && (cfg.index == CFG_FRAMES);
	assign clr_count = managed_count(cfg.data[CNT_W-1:0], FRAME_CAP);
	assign managed   = managed_count(frames_in_use_q, FRAME_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q     <= PAGE_SIZE_RESET;
			frames_in_use_q <= FRAMES_RESET;
		end else if (cfg_wr) begin
			if (cfg.index == CFG_PAGE_SIZE) begin
				page_size_q <= cfg.data[PS_W-1:0];
			end
			if (cfg.index == CFG_FRAMES) begin
				// rewriting the frame count also empties the table
				frames_in_use_q <= cfg.data[CNT_W-1:0];
			end
		end
	end

	pfa_ctrl #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.page_size (page_size_q),
		.clr       (clr),
		.clr_count (clr_count),
		.launch    (chain[0]),
		.tail      (chain[NUM_FRAMES]),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	pfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Row of frame cells: frame 0 at the head, so the claiming wave takes
	// the lowest-numbered free frames first.
	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		pfa_cell #(
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (clr),
			.managed  (managed),
			.wave_in  (chain[i]),
			.wave_out (chain[i+1])
		);
	end

endmodule
`default_nettype wire

[tb/tb_paging_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paging_frame_allocator - self-checking bench for the frame allocator
// Drives allocate and deallocate requests with random gaps and reply stalls.
// Rewrites the page size and frame count between phases. Checks every reply
// against a frame table kept inside the bench.
// ----------------------------------------------------------------------------
module tb_paging_frame_allocator;
	import pfa_pkg::*;

	localparam int FRAME_SLOTS = 64;
	localparam int GAP_MAX     = 17;

	// One pending transaction: a register write or a request.
	typedef struct {
		bit               is_write;
		logic [3:0]       reg_index;
		logic [15:0]      reg_value;
		logic             cmd;
		logic [15:0]      proc_id;
		logic [23:0]      proc_bytes;
		int unsigned      gap;
	} frame_job_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] frames_moved;
	} frame_reply_t;

	logic clk;
	logic arst_n = 1'b0;

	pfa_req_if req ();
	pfa_rsp_if rsp ();
	pfa_cfg_if cfg ();

	paging_frame_allocator #(
		.NUM_FRAMES(FRAME_SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// Frame table as the bench sees it: owner and held flag per frame, the
	// free count and both registers.
	// ------------------------------------------------------------------------
	logic [15:0]  owner_of [FRAME_SLOTS];
	bit           held [FRAME_SLOTS];
	int unsigned  frames_free;
	logic [15:0]  page_bytes;
	logic [6:0]   frame_limit;

	frame_job_t   job_q[$];
	frame_reply_t owed_replies[$];

	// Generator view of the registers, used only to size requests sensibly.
	logic [15:0]  gen_page;
	int unsigned  gen_frames;
	bit           send_calm;

	// Handshakes seen at the last rising edge, read by the falling-edge drivers.
	bit           req_taken;
	bit           cfg_taken;
	bit           rsp_taken;
	int unsigned  send_wait;
	int unsigned  hold_left;

	int unsigned  mismatches;
	int unsigned  replies_seen;
	int unsigned  requests_sent;
	int unsigned  writes_done;
	int unsigned  status_seen [4];

	function automatic int unsigned frames_managed();
		return (frame_limit > FRAME_SLOTS) ? FRAME_SLOTS : frame_limit;
	endfunction

	function automatic void wipe_frames();
		for (int i = 0; i < FRAME_SLOTS; i++) begin
			owner_of[i] = '0;
			held[i]     = 1'b0;
		end
		frames_free = frames_managed();
	endfunction

	// Work out one reply and advance the table. Only held frames count when
	// matching an id; a freed frame keeps its stale owner but is ignored.
	function automatic frame_reply_t allocate_or_release(logic cmd, logic [15:0] id,
		logic [23:0] bytes);
		int unsigned  lim;
		int unsigned  div;
		int unsigned  pages;
		int unsigned  moved;
		bit           owned;
		frame_reply_t r;
		lim    = frames_managed();
		moved  = 0;
		owned  = 1'b0;
		r.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			// A zero page size behaves as one byte per page.
			div   = (page_bytes == 0) ? 1 : page_bytes;
			pages = (bytes + div - 1) / div;
			for (int i = 0; i < lim; i++)
				if (held[i] && owner_of[i] == id)
					owned = 1'b1;
			// Size is checked first, so a request failing both reports no space.
			if (pages > frames_free)
				r.status = ST_NOSPACE;
			else if (owned)
				r.status = ST_DUP;
			else begin
				for (int i = 0; i < lim && moved < pages; i++) begin
					if (!held[i]) begin
						held[i]     = 1'b1;
						owner_of[i] = id;
						moved++;
					end
				end
				frames_free -= moved;
			end
		end else begin
			for (int i = 0; i < lim; i++) begin
				if (held[i] && owner_of[i] == id) begin
					held[i] = 1'b0;
					moved++;
				end
			end
			if (moved == 0)
				r.status = ST_UNKNOWN;
			frames_free += moved;
		end
		r.free_count   = frames_free[CNT_W-1:0];
		r.frames_moved = moved[CNT_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_gap(bit calm);
		return calm ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers: queue requests and register writes for the driver.
	// ------------------------------------------------------------------------
	function automatic void push_request(logic cmd, logic [15:0] id, logic [23:0] bytes);
		frame_job_t j;
		j.is_write   = 1'b0;
		j.reg_index  = CFG_PAGE_SIZE;
		j.reg_value  = '0;
		j.cmd        = cmd;
		j.proc_id    = id;
		j.proc_bytes = bytes;
		j.gap        = pick_gap(send_calm);
		job_q.push_back(j);
	endfunction

	function automatic void push_write(logic [3:0] idx, logic [15:0] val);
		frame_job_t j;
		j.is_write   = 1'b1;
		j.reg_index  = idx;
		j.reg_value  = val;
		j.cmd        = CMD_ALLOC;
		j.proc_id    = '0;
		j.proc_bytes = '0;
		j.gap        = pick_gap(send_calm);
		job_q.push_back(j);
		if (idx == CFG_PAGE_SIZE)
			gen_page = val;
		else
			gen_frames = val[6:0];
	endfunction

	// Byte size that rounds up to the given page count under the current page size.
	function automatic logic [23:0] bytes_for(int unsigned pages);
		int unsigned     ps;
		longint unsigned b;
		ps = (gen_page == 0) ? 1 : gen_page;
		if (pages == 0)
			return '0;
		if ($urandom_range(0, 3) == 0)
			b = longint'(pages) * ps;
		else
			b = longint'(pages - 1) * ps + $urandom_range(1, ps);
		if (b > 24'hFF_FFFF)
			b = 24'hFF_FFFF;
		return b[23:0];
	endfunction

	// Mostly well-formed traffic on a small pool of ids, so that allocations
	// collide, duplicates show up and frees find their owners; the rest is noise.
	function automatic void random_phase(int count);
		logic [15:0] pool [6];
		int unsigned cap;
		int unsigned pages;
		int unsigned roll;
		logic [15:0] id;
		for (int k = 0; k < 6; k++)
			pool[k] = 16'($urandom_range(0, 16'hFFFF));
		cap = ((gen_frames > FRAME_SLOTS) ? FRAME_SLOTS : gen_frames) + 2;
		for (int n = 0; n < count; n++) begin
			if (n % 30 == 0)
				send_calm = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			id   = pool[$urandom_range(0, 5)];
			if (roll < 12) begin
				push_request(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
					24'($urandom_range(0, 24'hFF_FFFF)));
			end else if (roll < 58) begin
				pages = ($urandom_range(0, 2) != 0) ? $urandom_range(0, cap / 4 + 1)
					: $urandom_range(0, cap);
				push_request(CMD_ALLOC, id, bytes_for(pages));
			end else begin
				push_request(CMD_FREE, id, 24'($urandom_range(0, 24'hFF_FFFF)));
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Monitor: sample every handshake at the rising edge, advance the table on
	// each accepted request or write, and check each reply against the oldest
	// one owed.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		frame_reply_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
			cfg_taken <= 1'b0;
			rsp_taken <= 1'b0;
		end else begin
			req_taken <= req.valid && req.ready;
			cfg_taken <= cfg.valid && cfg.ready;
			rsp_taken <= rsp.valid && rsp.ready;
			if (cfg.valid && cfg.ready) begin
				writes_done++;
				if (cfg.index == CFG_PAGE_SIZE)
					page_bytes = cfg.data;
				else if (cfg.index == CFG_FRAMES) begin
					// A new frame count empties the whole table.
					frame_limit = cfg.data[6:0];
					wipe_frames();
				end
			end
			if (req.valid && req.ready) begin
				requests_sent++;
				owed_replies.push_back(allocate_or_release(req.cmd, req.proc_id,
					req.proc_bytes));
			end
			if (rsp.valid && rsp.ready) begin
				replies_seen++;
				if (owed_replies.size() == 0) begin
					$error("reply with none owed: status %0d free_count %0d frames_moved %0d",
						rsp.status, rsp.free_count, rsp.frames_moved);
					mismatches++;
				end else begin
					want = owed_replies.pop_front();
					status_seen[want.status]++;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						mismatches++;
					end
					if (rsp.free_count !== want.free_count) begin
						$error("free_count: expected %0d, got %0d", want.free_count,
							rsp.free_count);
						mismatches++;
					end
					if (rsp.frames_moved !== want.frames_moved) begin
						$error("frames_moved: expected %0d, got %0d", want.frames_moved,
							rsp.frames_moved);
						mismatches++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver: change inputs at the falling edge only. Hold a transaction until
	// its handshake, then wait out its drawn gap before the next. Release a
	// register write only once every owed reply is back, so it lands on an
	// idle block. Each valid is assigned once per step.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		logic       nxt_req_valid;
		logic       nxt_cfg_valid;
		frame_job_t j;
		if (!arst_n) begin
			req.valid <= 1'b0;
			cfg.valid <= 1'b0;
			send_wait = 0;
		end else begin
			nxt_req_valid = req.valid;
			nxt_cfg_valid = cfg.valid;
			if (req.valid && req_taken)
				nxt_req_valid = 1'b0;
			if (cfg.valid && cfg_taken)
				nxt_cfg_valid = 1'b0;
			if (!nxt_req_valid && !nxt_cfg_valid) begin
				if (send_wait > 0)
					send_wait--;
				else if (job_q.size() > 0) begin
					j = job_q[0];
					if (j.is_write) begin
						if (owed_replies.size() == 0) begin
							cfg.index     <= j.reg_index;
							cfg.data      <= j.reg_value;
							nxt_cfg_valid = 1'b1;
							send_wait     = j.gap;
							void'(job_q.pop_front());
						end
					end else begin
						req.cmd        <= j.cmd;
						req.proc_id    <= j.proc_id;
						req.proc_bytes <= j.proc_bytes;
						nxt_req_valid  = 1'b1;
						send_wait      = j.gap;
						void'(job_q.pop_front());
					end
				end
			end
			req.valid <= nxt_req_valid;
			cfg.valid <= nxt_cfg_valid;
		end
	end

	// Reply side: after each reply stall for a drawn number of cycles; every
	// third stretch of replies runs without stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_taken)
				hold_left = pick_gap(((replies_seen / 160) % 3) == 2);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Scenario: directed requests on the reset settings, then random phases
	// across page sizes and frame counts, extremes and out-of-range included.
	// ------------------------------------------------------------------------
	initial begin
		req.valid      = 1'b0;
		req.cmd        = CMD_ALLOC;
		req.proc_id    = '0;
		req.proc_bytes = '0;
		cfg.valid      = 1'b0;
		cfg.index      = CFG_PAGE_SIZE;
		cfg.data       = '0;
		rsp.ready      = 1'b0;
		mismatches     = 0;
		replies_seen   = 0;
		requests_sent  = 0;
		writes_done    = 0;
		for (int s = 0; s < 4; s++)
			status_seen[s] = 0;

		page_bytes  = PAGE_SIZE_RESET;
		frame_limit = FRAMES_RESET;
		wipe_frames();
		gen_page   = PAGE_SIZE_RESET;
		gen_frames = FRAMES_RESET;
		send_calm  = 1'b0;

		// Zero-byte allocate succeeds without claiming, and again for the same id.
		push_request(CMD_ALLOC, 16'h0000, 24'd0);
		push_request(CMD_ALLOC, 16'h0000, 24'd0);
		push_request(CMD_FREE,  16'h0000, 24'd0);
		// Round up, exact fit, duplicate id.
		push_request(CMD_ALLOC, 16'h0001, 24'd1);
		push_request(CMD_ALLOC, 16'h0001, 24'd4096);
		push_request(CMD_ALLOC, 16'hFFFF, 24'd4096);
		push_request(CMD_ALLOC, 16'hFFFF, 24'd4097);
		push_request(CMD_ALLOC, 16'h0002, 24'd4097);
		// Too big, and too big as well as a duplicate: no space wins.
		push_request(CMD_ALLOC, 16'h0003, 24'hFF_FFFF);
		push_request(CMD_ALLOC, 16'h0001, 24'hFF_FFFF);
		// Free a hole at the bottom and refill it first fit.
		push_request(CMD_FREE,  16'h0001, 24'hFF_FFFF);
		push_request(CMD_ALLOC, 16'h0004, 24'd4096);
		// Run the table dry.
		push_request(CMD_ALLOC, 16'h0005, 24'd237568);
		push_request(CMD_ALLOC, 16'h0006, 24'd12288);
		push_request(CMD_ALLOC, 16'h0006, 24'd8192);
		push_request(CMD_ALLOC, 16'h0007, 24'd0);
		push_request(CMD_ALLOC, 16'h0008, 24'd1);
		// Release everything; a stale owner must not match.
		push_request(CMD_FREE,  16'h0005, 24'd0);
		push_request(CMD_FREE,  16'h8000, 24'd0);
		push_request(CMD_FREE,  16'h0001, 24'd0);
		push_request(CMD_FREE,  16'hFFFF, 24'd0);
		push_request(CMD_FREE,  16'h0002, 24'd0);
		push_request(CMD_FREE,  16'h0004, 24'd0);
		push_request(CMD_FREE,  16'h0006, 24'd0);
		// Whole table to one id and back.
		push_request(CMD_ALLOC, 16'h0009, 24'd262144);
		push_request(CMD_FREE,  16'h0009, 24'd0);

		push_write(CFG_PAGE_SIZE, 16'd1);
		random_phase(170);
		push_write(CFG_PAGE_SIZE, 16'hFFFF);
		random_phase(150);
		// Zero page size behaves as one byte per page.
		push_write(CFG_FRAMES, 16'd16);
		push_write(CFG_PAGE_SIZE, 16'd0);
		random_phase(170);
		push_write(CFG_PAGE_SIZE, 16'd256);
		push_write(CFG_FRAMES, 16'd1);
		random_phase(120);
		// No frames managed: any nonzero allocate is refused.
		push_write(CFG_FRAMES, 16'd0);
		random_phase(60);
		// Out-of-range counts clamp to the table size.
		push_write(CFG_FRAMES, 16'd127);
		push_write(CFG_PAGE_SIZE, 16'd4096);
		random_phase(170);
		push_write(CFG_PAGE_SIZE, 16'd100);
		push_write(CFG_FRAMES, 16'd65);
		random_phase(150);
		push_write(CFG_FRAMES, 16'd64);
		push_write(CFG_PAGE_SIZE, 16'd7);
		random_phase(170);
		for (int p = 0; p < 3; p++) begin
			push_write(CFG_FRAMES, 16'($urandom_range(1, 64)));
			push_write(CFG_PAGE_SIZE, 16'($urandom_range(1, 16'hFFFF)));
			random_phase(220);
		end

		// Release reset at a falling edge so no sampling edge sees it move.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every reply back, then let the block settle.
		do
			@(posedge clk);
		while (job_q.size() != 0 || req.valid || cfg.valid || owed_replies.size() != 0);
		repeat (200) @(posedge clk);

		$display("Covered %0d requests and %0d register writes, %0d replies checked.",
			requests_sent, writes_done, replies_seen);
		$display("Replies by status: ok %0d, no space %0d, duplicate %0d, unknown %0d.",
			status_seen[ST_OK], status_seen[ST_NOSPACE], status_seen[ST_DUP],
			status_seen[ST_UNKNOWN]);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
